>>> src/base64_stream_encoder_defines.svh
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define B64E_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define B64E_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> src/b64e_pkg.sv
// shared types, character codes and symbol mapping for the base64 encoder
package b64e_pkg;

    localparam int unsigned SYM_W      = 6;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned SLOTS      = 4;
    localparam int unsigned Q_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 7'h30;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 7'h2F;
    localparam logic [CHAR_W-1:0] CH_EQUALS  = 7'h3D;
    localparam logic [CHAR_W-1:0] CH_STAR    = 7'h2A;
    localparam logic [CHAR_W-1:0] CH_DASH    = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 7'h5F;

    localparam logic [SYM_W-1:0] SYM_LAST_UPPER = 6'd25;
    localparam logic [SYM_W-1:0] SYM_LAST_LOWER = 6'd51;
    localparam logic [SYM_W-1:0] SYM_LAST_DIGIT = 6'd61;
    localparam logic [SYM_W-1:0] SYM_PLUS       = 6'd62;

    // position of the next byte within its three-byte group
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    // one request's worth of work for the back end
    typedef struct packed {
        logic [SLOTS-1:0][SYM_W-1:0] sym;
        logic [SLOTS-1:0]            pad;
        logic [1:0]                  cnt_m1;
        logic                        last;
    } entry_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] carry;
    } front_status_t;

    function automatic logic [CHAR_W-1:0] sym_to_ascii(
        input logic [SYM_W-1:0] v,
        input logic             alt
    );
        logic [CHAR_W-1:0] v7;
        logic [CHAR_W-1:0] res;
        v7 = {1'b0, v};
        priority if (v <= SYM_LAST_UPPER)
            res = CH_UPPER_A + v7;
        else if (v <= SYM_LAST_LOWER)
            res = CH_LOWER_A + v7 - 7'd26;
        else if (v <= SYM_LAST_DIGIT)
            res = CH_DIGIT_0 + v7 - 7'd52;
        else if (v == SYM_PLUS)
            res = alt ? CH_STAR : CH_PLUS;
        else
            res = alt ? CH_DASH : CH_SLASH;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] pad_char(input logic alt);
        return alt ? CH_UNDER : CH_EQUALS;
    endfunction

endpackage

>>> src/b64e_front.sv
// front end: takes bytes, tracks group phase and splits each byte into symbols
module b64e_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_message,
    input  logic                    q_full,
    output logic                    q_push,
    output b64e_pkg::entry_t        q_entry,
    output b64e_pkg::front_status_t status
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    assign q_push = push && !q_full;
    assign status = '{phase: phase_reg, carry: carry_reg};

    always_comb
    begin
        q_entry    = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            PH_1:
            begin
                q_entry.sym[0] = {carry_reg[1:0], data_byte[7:4]};
                if (end_of_message)
                begin
                    q_entry.sym[1] = {data_byte[3:0], 2'b00};
                    q_entry.pad[2] = 1'b1;
                    q_entry.cnt_m1 = 2'd2;
                end
                else
                begin
                    carry_next = data_byte[3:0];
                    phase_next = PH_2;
                end
            end
            PH_2:
            begin
                q_entry.sym[0] = {carry_reg, data_byte[7:6]};
                q_entry.sym[1] = data_byte[5:0];
                q_entry.cnt_m1 = 2'd1;
                carry_next     = 4'd0;
                phase_next     = PH_0;
            end
            default:
            begin
                // start of a group; an unreachable code behaves the same
                q_entry.sym[0] = data_byte[7:2];
                if (end_of_message)
                begin
                    q_entry.sym[1] = {data_byte[1:0], 4'b0000};
                    q_entry.pad[2] = 1'b1;
                    q_entry.pad[3] = 1'b1;
                    q_entry.cnt_m1 = 2'd3;
                end
                else
                begin
                    carry_next = {2'b00, data_byte[1:0]};
                    phase_next = PH_1;
                end
            end
        endcase
        q_entry.last = end_of_message;
        if (end_of_message)
        begin
            phase_next = PH_0;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

>>> src/b64e_queue.sv
// short request queue between front and back end
module b64e_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::entry_t wr_entry,
    output logic             full,
    input  logic             pop,
    output b64e_pkg::entry_t rd_entry,
    output logic             empty
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(Q_DEPTH);

    entry_t           slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_MAX);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

>>> src/b64e_back.sv
// back end: walks each request into the output register one character a cycle while that register is free
module b64e_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        alt,
    input  b64e_pkg::entry_t            q_entry,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [b64e_pkg::CHAR_W-1:0] out_char,
    output logic                        out_last
);
    import b64e_pkg::*;

    entry_t            cur_reg;
    logic              cur_valid_reg;
    logic [1:0]        idx_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              advance;
    logic              at_end;
    logic              take;
    logic [CHAR_W-1:0] slot_char;

    assign out_free = !out_valid_reg || pop;
    assign advance  = out_free && cur_valid_reg;
    assign at_end   = (idx_reg == cur_reg.cnt_m1);
    assign take     = !cur_valid_reg || (advance && at_end);
    assign q_pop    = take && !q_empty;

    assign slot_char = cur_reg.pad[idx_reg] ? pad_char(alt)
                                            : sym_to_ascii(cur_reg.sym[idx_reg], alt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (advance && at_end)
                cur_valid_reg <= 1'b0;
            else if (advance)
                idx_reg <= idx_reg + 1'b1;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_entry;
        if (advance)
        begin
            out_char_reg <= slot_char;
            out_last_reg <= at_end && cur_reg.last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

endmodule

>>> src/base64_stream_encoder.sv
// top level of the streaming base64 encoder
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+----------------------------
//  bytes in  | data_byte, end_of_message              | push / full
//  chars out | out_char, out_last                     | pop / empty
//  config    | cfg_wdata (alt alphabet)               | cfg_we, no wait
//
// a byte is taken in any cycle the request queue has room; the back end then
// emits one character per cycle, one to four per byte (four thirds on average)
// while its output is free, so the back end's serialiser sets the sustained rate
// a first character passes the request queue, the back end's request register
// and its output register; reset clears phase, carry, queue, back end and the
// alphabet select at once; a stalled output holds its character; the front keeps
// taking bytes until the two-deep request queue fills
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_message,
    input  logic                        pop,
    output logic                        empty,
    output logic [b64e_pkg::CHAR_W-1:0] out_char,
    output logic                        out_last,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata
);
    import b64e_pkg::*;

    // alphabet select; change only while the encoder is idle, the block does not enforce this
    logic          alt_reg;

    // front to queue
    logic          q_push;
    logic          q_full;
    entry_t        q_wr_entry;
    front_status_t front_status;

    // queue to back
    logic          q_pop;
    logic          q_empty;
    entry_t        q_rd_entry;

    // message end taken, and front back at a clean group start
    logic          q_push_eom;
    logic          front_clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alt_reg <= 1'b0;
        else if (cfg_we)
            alt_reg <= cfg_wdata;
    end

    assign full = q_full;

    // front: phase tracking and splitting each byte into its symbols and pads
    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_wr_entry),
        .status         (front_status)
    );

    // decouples byte intake from character output
    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    // back: alphabet mapping and one character per cycle, while the output register is free, into it
    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .alt      (alt_reg),
        .q_entry  (q_rd_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .out_last (out_last)
    );

    assign q_push_eom  = q_push && end_of_message;
    assign front_clear = (front_status.phase == PH_0) && (front_status.carry == 4'd0);

    // the front only writes the queue when it has room
    `B64E_ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full), "request queue overflow")
    // the back only loads a request that is there
    `B64E_ASSERT_ALWAYS(a_no_underflow, !(q_pop && q_empty), "request queue underflow")
    // a message end returns the front to the start of a group with no carry
    `B64E_ASSERT_NEXT(a_end_resets, q_push_eom, front_clear, "group state not cleared")

endmodule

>>> dv/base64_char_compare.sv
// character predictor and in-order comparison for the base64 stream encoder
module base64_char_compare (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_message,
    input  logic                        pop,
    input  logic                        empty,
    input  logic [b64e_pkg::CHAR_W-1:0] out_char,
    input  logic                        out_last,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    output int                          mismatch_count,
    output int                          chars_pending,
    output int                          chars_checked
);
    import b64e_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } enc_char_t;

    enc_char_t   expected_chars[$];
    logic        alt_sel;
    logic [1:0]  grp_pos;
    logic [3:0]  held_bits;
    int          bad_cnt;
    int          good_cnt;

    function automatic logic [CHAR_W-1:0] sym_char(input logic [5:0] s, input logic alt);
        logic [CHAR_W-1:0] c;
        if (s < 6'd26)
            c = CH_UPPER_A + 7'(s);
        else if (s < 6'd52)
            c = CH_LOWER_A + 7'(s - 6'd26);
        else if (s < 6'd62)
            c = CH_DIGIT_0 + 7'(s - 6'd52);
        else if (s == 6'd62)
            c = alt ? CH_STAR : CH_PLUS;
        else
            c = alt ? CH_DASH : CH_SLASH;
        return c;
    endfunction

    task automatic want(input logic [CHAR_W-1:0] code, input logic last);
        enc_char_t e;
        e.code = code;
        e.last = last;
        expected_chars.push_back(e);
    endtask

    // one byte in, one to four characters out
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [CHAR_W-1:0] pad;
        pad = alt_sel ? CH_UNDER : CH_EQUALS;
        case (grp_pos)
            2'd1:
            begin
                want(sym_char({held_bits[1:0], b[7:4]}, alt_sel), 1'b0);
                if (eom)
                begin
                    want(sym_char({b[3:0], 2'b00}, alt_sel), 1'b0);
                    want(pad, 1'b1);
                end
                held_bits = b[3:0];
                grp_pos   = 2'd2;
            end
            2'd2:
            begin
                want(sym_char({held_bits, b[7:6]}, alt_sel), 1'b0);
                want(sym_char(b[5:0], alt_sel), eom);
                held_bits = 4'd0;
                grp_pos   = 2'd0;
            end
            default:
            begin
                if (eom)
                begin
                    want(sym_char(b[7:2], alt_sel), 1'b0);
                    want(sym_char({b[1:0], 4'b0000}, alt_sel), 1'b0);
                    want(pad, 1'b0);
                    want(pad, 1'b1);
                end
                else
                    want(sym_char(b[7:2], alt_sel), 1'b0);
                held_bits = {2'b00, b[1:0]};
                grp_pos   = 2'd1;
            end
        endcase
        if (eom)
        begin
            grp_pos   = 2'd0;
            held_bits = 4'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_char_t e;
        if (!rst_n)
        begin
            expected_chars.delete();
            alt_sel        = 1'b0;
            grp_pos        = 2'd0;
            held_bits      = 4'd0;
            bad_cnt        = 0;
            good_cnt       = 0;
            mismatch_count <= 0;
            chars_pending  <= 0;
            chars_checked  <= 0;
        end
        else
        begin
            if (cfg_we)
                alt_sel = cfg_wdata;
            if (push && !full)
                encode_byte(data_byte, end_of_message);
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    bad_cnt++;
                    $display("%0t: unexpected char %h last %b", $time, out_char, out_last);
                end
                else
                begin
                    e = expected_chars.pop_front();
                    good_cnt++;
                    if (out_char !== e.code || out_last !== e.last)
                    begin
                        bad_cnt++;
                        $display("%0t: char mismatch expected %h last %b, got %h last %b",
                                 $time, e.code, e.last, out_char, out_last);
                    end
                end
            end
            mismatch_count <= bad_cnt;
            chars_pending  <= expected_chars.size();
            chars_checked  <= good_cnt;
        end
    end

endmodule

>>> dv/base64_stream_encoder_tb.sv
// stimulus and verdict for the base64 stream encoder, checked beside the block
module base64_stream_encoder_tb;
    import b64e_pkg::*;

    // watchdog limit on the length of the run
    localparam int RUN_LIMIT   = 200000;
    localparam int SEG_BYTES   = 75;
    localparam int TAIL_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [7:0]        data_byte      = 8'h00;
    logic              end_of_message = 1'b0;
    logic              pop            = 1'b0;
    logic              empty;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              cfg_we         = 1'b0;
    logic              cfg_wdata      = 1'b0;

    int mismatch_count;
    int chars_pending;
    int chars_checked;

    // idle odds in percent, changed between segments of the run
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int msgs_sent     = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    base64_stream_encoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .pop            (pop),
        .empty          (empty),
        .out_char       (out_char),
        .out_last       (out_last),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    base64_char_compare u_compare (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .pop            (pop),
        .empty          (empty),
        .out_char       (out_char),
        .out_last       (out_last),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending),
        .chars_checked  (chars_checked)
    );

    // receiver side: one fresh pop decision per cycle, held low through reset
    always @(posedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // watchdog: a hung handshake or a lost character ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one request per byte; push only drops when the sender idles or drains, so
    // back-to-back requests never see push lowered and raised in one step
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // whole message, end flag on its final byte
    task automatic send_message(input byte_q_t msg);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
        msgs_sent++;
    endtask

    // wait until every predicted character has come out; the extra edge first
    // lets the checker's count catch up with the request just taken
    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // alphabet select is only touched with the block idle
    task automatic set_alphabet(input logic alt);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= alt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // random messages, mostly short with the odd longer one, until the
    // segment has its share of bytes
    task automatic random_segment(input int s_idle, input int r_idle, input logic alt);
        byte_q_t msg;
        int      len;
        int      seg_cnt;
        set_alphabet(alt);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        seg_cnt       = 0;
        while (seg_cnt < SEG_BYTES)
        begin
            msg.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            repeat (len)
                msg.push_back(8'($urandom_range(255)));
            send_message(msg);
            seg_cnt += len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with a light sender stall and a slow receiver
        send_idle_pct = 28;
        recv_idle_pct = 79;

        // standard alphabet straight out of reset: a lone byte flushes with
        // two pads, two bytes with one pad, a full group with none
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'hFB, 8'hFF});
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h00, 8'h10, 8'h83});
        send_message('{8'h80, 8'h7F, 8'h01, 8'hFE});

        // alternative alphabet: star, dash and underscore take over
        set_alphabet(1'b1);
        send_message('{8'hFB, 8'hFF});
        send_message('{8'hFF});
        send_message('{8'hFB, 8'hEF, 8'hBE});

        // random part: slow receiver, then slow sender, then full rate
        random_segment(28, 79, 1'b1);
        random_segment(28, 79, 1'b0);
        random_segment(79, 28, 1'b1);
        random_segment(79, 28, 1'b0);
        random_segment(0, 0, 1'b1);
        random_segment(0, 0, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d bytes in %0d messages encoded, %0d characters checked",
                 bytes_sent, msgs_sent, chars_checked);
        $display("tb: both alphabets, every flush length, stalls on either side and full rate");
        if (mismatch_count == 0 && chars_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
